@@ hdl/sgpid_pkg.sv @@
// Shared constants, register indexes and stage payload types of the split-gain PID drive.
`timescale 1ns / 1ps
package sgpid_pkg;

	// Field widths fixed by the data formats.
	localparam int ErrW   = 16;
	localparam int GainW  = 16;
	localparam int IntW   = 24;
	localparam int DiffW  = 17;
	localparam int CfgW   = 48;
	localparam int IdxW   = 3;
	localparam int PowerW = 11;

	// Register indexes of the configuration port.
	localparam logic [IdxW-1:0] REG_GAINS_UP      = 3'd0;
	localparam logic [IdxW-1:0] REG_GAINS_DOWN    = 3'd1;
	localparam logic [IdxW-1:0] REG_DEAD_BAND     = 3'd2;
	localparam logic [IdxW-1:0] REG_ERROR_LIMIT   = 3'd3;
	localparam logic [IdxW-1:0] REG_INT_LIMIT_UP  = 3'd4;
	localparam logic [IdxW-1:0] REG_INT_LIMIT_DN  = 3'd5;
	localparam logic [IdxW-1:0] REG_POWER_LIMIT   = 3'd6;

	// Reset values of the limit registers.
	localparam logic [14:0] ErrorLimitReset = 15'd32767;
	localparam logic [22:0] IntLimitReset   = 23'd8388607;
	localparam logic [9:0]  PowerLimitReset = 10'd700;

	// Plus or minus 100 percent in Q.16.
	localparam int PctLimit = 100 * 65536;

	// Rounding bias for truncation toward zero of a negative Q.16 value.
	localparam int FracBias = 65535;

	// Configuration register set.
	typedef struct packed {
		logic [CfgW-1:0] gains_up;
		logic [CfgW-1:0] gains_down;
		logic [14:0]     dead_band;
		logic [14:0]     error_limit;
		logic [22:0]     int_limit_up;
		logic [22:0]     int_limit_down;
		logic [9:0]      power_limit;
	} cfg_t;

	// Conditioned terms and selected gains, handed to the multiply stage.
	typedef struct packed {
		logic                    down;
		logic signed [ErrW-1:0]  err;
		logic signed [IntW-1:0]  integ;
		logic signed [DiffW-1:0] diff;
		logic [GainW-1:0]        kp;
		logic [GainW-1:0]        ki;
		logic [GainW-1:0]        kd;
	} cond_t;

	// Exact Q.16 products, handed to the output stage.
	typedef struct packed {
		logic               down;
		logic signed [32:0] p_prop;
		logic signed [40:0] p_int;
		logic signed [33:0] p_der;
	} prod_t;

endpackage

@@ hdl/sgpid_in_if.sv @@
// Handshake channel that carries one error sample per item.
`timescale 1ns / 1ps
interface sgpid_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface

@@ hdl/sgpid_out_if.sv @@
// Handshake channel that carries one motor power result per item.
`timescale 1ns / 1ps
interface sgpid_out_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] motor_power;
	logic               used_down_set;

	modport source (output valid, output motor_power, output used_down_set, input ready);
	modport sink (input valid, input motor_power, input used_down_set, output ready);
endinterface

@@ hdl/sgpid_cfg_regs.sv @@
// Configuration register file of the split-gain PID drive.
`timescale 1ns / 1ps
module sgpid_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [sgpid_pkg::IdxW-1:0] cfg_index,
	input  logic [sgpid_pkg::CfgW-1:0] cfg_data,
	output sgpid_pkg::cfg_t          cfg
);
	import sgpid_pkg::*;

	cfg_t cfg_q;

	// Write decoder; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gains_up       <= '0;
			cfg_q.gains_down     <= '0;
			cfg_q.dead_band      <= '0;
			cfg_q.error_limit    <= ErrorLimitReset;
			cfg_q.int_limit_up   <= IntLimitReset;
			cfg_q.int_limit_down <= IntLimitReset;
			cfg_q.power_limit    <= PowerLimitReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAINS_UP:     cfg_q.gains_up       <= cfg_data;
				REG_GAINS_DOWN:   cfg_q.gains_down     <= cfg_data;
				REG_DEAD_BAND:    cfg_q.dead_band      <= cfg_data[14:0];
				REG_ERROR_LIMIT:  cfg_q.error_limit    <= cfg_data[14:0];
				REG_INT_LIMIT_UP: cfg_q.int_limit_up   <= cfg_data[22:0];
				REG_INT_LIMIT_DN: cfg_q.int_limit_down <= cfg_data[22:0];
				REG_POWER_LIMIT:  cfg_q.power_limit    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

@@ hdl/sgpid_condition.sv @@
// Input register, error conditioning, integrator and derivative state.
`timescale 1ns / 1ps
module sgpid_condition (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_vld,
	input  logic signed [sgpid_pkg::ErrW-1:0] in_err,
	input  sgpid_pkg::cfg_t            cfg,
	output logic                       vld_s2,
	output sgpid_pkg::cond_t           cond_s2
);
	import sgpid_pkg::*;

	logic                    vld_s1;
	logic signed [ErrW-1:0]  err_s1;
	logic signed [IntW-1:0]  integ_q;
	logic signed [ErrW-1:0]  prev_q;

	logic                    down;
	logic signed [16:0]      ext;
	logic [16:0]             mag;
	logic signed [16:0]      db_e;
	logic signed [16:0]      lim_e;
	logic signed [16:0]      ce17;
	logic signed [ErrW-1:0]  ce;
	logic signed [24:0]      isum;
	logic signed [24:0]      ilim;
	logic signed [24:0]      iclamp;
	logic signed [DiffW-1:0] diff;
	logic [CfgW-1:0]         gains;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_vld) begin
			err_s1 <= in_err;
		end
	end

	// The raw sign selects the gain set; then dead band and error clamp.
	assign down  = err_s1[ErrW-1];
	assign ext   = 17'(err_s1);
	assign mag   = down ? 17'(-ext) : 17'(ext);
	assign db_e  = (mag < {2'b00, cfg.dead_band}) ? '0 : ext;
	assign lim_e = $signed({2'b00, cfg.error_limit});
	assign ce17  = (db_e > lim_e) ? lim_e : ((db_e < -lim_e) ? -lim_e : db_e);
	assign ce    = ce17[ErrW-1:0];

	// Integrator with the selected set's symmetric limit.
	assign isum   = 25'(integ_q) + 25'(ce);
	assign ilim   = $signed({2'b00, (down ? cfg.int_limit_down : cfg.int_limit_up)});
	assign iclamp = (isum > ilim) ? ilim : ((isum < -ilim) ? -ilim : isum);

	// Derivative against the last conditioned error.
	assign diff  = 17'(ce) - 17'(prev_q);
	assign gains = down ? cfg.gains_down : cfg.gains_up;

	// Controller state advances once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			vld_s2  <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				integ_q <= iclamp[IntW-1:0];
				prev_q  <= ce;
			end
		end
	end

	// Stage register toward the multipliers.
	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			cond_s2.down  <= down;
			cond_s2.err   <= ce;
			cond_s2.integ <= iclamp[IntW-1:0];
			cond_s2.diff  <= diff;
			cond_s2.kp    <= gains[15:0];
			cond_s2.ki    <= gains[31:16];
			cond_s2.kd    <= gains[47:32];
		end
	end
endmodule

@@ hdl/sgpid_mult.sv @@
// Three parallel gain multipliers with a registered result.
`timescale 1ns / 1ps
module sgpid_mult (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_s2,
	input  sgpid_pkg::cond_t cond_s2,
	output logic             vld_s3,
	output sgpid_pkg::prod_t prod_s3
);
	import sgpid_pkg::*;

	logic signed [32:0] p_prop;
	logic signed [40:0] p_int;
	logic signed [33:0] p_der;

	// Signed term times unsigned gain, each exact in Q.16.
	assign p_prop = 33'(cond_s2.err)   * 33'($signed({1'b0, cond_s2.kp}));
	assign p_int  = 41'(cond_s2.integ) * 41'($signed({1'b0, cond_s2.ki}));
	assign p_der  = 34'(cond_s2.diff)  * 34'($signed({1'b0, cond_s2.kd}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			prod_s3.down   <= cond_s2.down;
			prod_s3.p_prop <= p_prop;
			prod_s3.p_int  <= p_int;
			prod_s3.p_der  <= p_der;
		end
	end
endmodule

@@ hdl/sgpid_output.sv @@
// PID sum, percent clamp, scaling to tenths, power clamp and result register.
`timescale 1ns / 1ps
module sgpid_output (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_s3,
	input  sgpid_pkg::prod_t prod_s3,
	input  logic [9:0]       power_limit,
	output logic             vld_q,
	output logic signed [sgpid_pkg::PowerW-1:0] power_q,
	output logic             down_q
);
	import sgpid_pkg::*;

	logic signed [41:0] psum;
	logic signed [23:0] c1;
	logic signed [27:0] x10;
	logic signed [27:0] plim;
	logic signed [27:0] c2;
	logic signed [27:0] rnd;
	logic signed [27:0] whole;

	// Exact sum of the three terms, percent in Q.16.
	assign psum = 42'(prod_s3.p_prop) + 42'(prod_s3.p_int) + 42'(prod_s3.p_der);

	// Clamp to plus or minus 100 percent.
	assign c1 = (psum > 42'(PctLimit)) ? 24'(PctLimit) :
		((psum < -42'(PctLimit)) ? -24'(PctLimit) : psum[23:0]);

	// Times ten as shift and add, then the power limit.
	assign x10  = (28'(c1) <<< 3) + (28'(c1) <<< 1);
	assign plim = $signed({2'b00, power_limit, 16'h0000});
	assign c2   = (x10 > plim) ? plim : ((x10 < -plim) ? -plim : x10);

	// Truncate toward zero to whole tenths.
	assign rnd   = c2[27] ? (c2 + 28'(FracBias)) : c2;
	assign whole = rnd >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			power_q <= whole[PowerW-1:0];
			down_q  <= prod_s3.down;
		end
	end
endmodule

@@ hdl/split_gain_pid_motor_drive.sv @@
// Top level of the split-gain PID motor drive.
`timescale 1ns / 1ps
// Usage:
// Each item on the samples channel is one signed Q8.8 control error. Each item
// leaves one item on the powers channel: motor power in tenths of percent and
// a flag telling whether the down gain set (negative raw error) was used.
// The configuration port writes one register when cfg_we is high; register
// writes belong to idle periods, when no item is in flight.
// The result passes the input register, the conditioning stage, the multiply
// stage and the result register. Throughput is one item per cycle unless the
// receiver stalls; the integrator and the previous error are updated in the
// conditioning stage, so the add-and-clamp loop there sets the rate.
// When the receiver stalls, the whole pipeline holds and samples.ready drops;
// as soon as powers.ready returns, an item is accepted in the same cycle.
// Reset clears the integrator and the previous error to zero, empties the
// pipeline and returns all registers to their documented reset values.
module split_gain_pid_motor_drive (
	input  logic                        clk,
	input  logic                        arst_n,
	sgpid_in_if.sink                    samples,
	sgpid_out_if.source                 powers,
	input  logic                        cfg_we,
	input  logic [sgpid_pkg::IdxW-1:0]  cfg_index,
	input  logic [sgpid_pkg::CfgW-1:0]  cfg_data
);
	import sgpid_pkg::*;

	cfg_t  cfg;
	cond_t cond_s2;
	prod_t prod_s3;
	logic  vld_s2;
	logic  vld_s3;
	logic  adv;

	// The pipeline moves unless a finished item waits at the output.
	assign adv           = !powers.valid || powers.ready;
	assign samples.ready = adv;

	sgpid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sgpid_condition u_cond (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (samples.valid),
		.in_err  (samples.error_sample),
		.cfg     (cfg),
		.vld_s2  (vld_s2),
		.cond_s2 (cond_s2)
	);

	sgpid_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s2  (vld_s2),
		.cond_s2 (cond_s2),
		.vld_s3  (vld_s3),
		.prod_s3 (prod_s3)
	);

	sgpid_output u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.vld_s3      (vld_s3),
		.prod_s3     (prod_s3),
		.power_limit (cfg.power_limit),
		.vld_q       (powers.valid),
		.power_q     (powers.motor_power),
		.down_q      (powers.used_down_set)
	);

	// A delivered power never exceeds the 100 percent bound.
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		powers.valid |-> (powers.motor_power <= 11'sd1000 &&
			powers.motor_power >= -11'sd1000))
		else $error("motor power outside plus or minus 1000");

	// An item in the multiply stage moves on when the pipeline advances.
	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s2) |=> vld_s3)
		else $error("item lost between multiply input and output stage");

	// A stalled pipeline holds the multiply stage contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && vld_s3) |=> (vld_s3 && $stable(prod_s3)))
		else $error("multiply stage changed during a stall");
endmodule
